/* sv/lrs_pkg.sv */
`timescale 1ns / 1ps

package lrs_pkg;

  localparam int SMP_W = 16;
  localparam int VOL_W = 7;
  localparam logic [VOL_W-1:0] VOL_MAX = 7'd100;

  localparam int P2_W = 22;
  localparam int M2_W = 23;
  localparam int S2 = 29;
  localparam logic [M2_W-1:0] M2 = 23'd5368710;

  typedef struct packed {
    logic load;
    logic issue;
    logic a_cur;
    logic frame_end;
    logic last_of_run;
  } lrs_cmd_t;

endpackage

/* sv/lrs_ctrl.sv */
`timescale 1ns / 1ps

module lrs_ctrl #(
  parameter int IN_FRAME = 371,
  parameter int OUT_FRAME = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          dp_en,
  output lrs_pkg::lrs_cmd_t             cmd,
  output logic [$clog2(OUT_FRAME)-1:0]  cmd_frac
);

  localparam int D = OUT_FRAME - 1;
  localparam int STEP = IN_FRAME - 1;
  localparam int RW = $clog2(OUT_FRAME);
  localparam int LW = $clog2(IN_FRAME);
  localparam int OW = $clog2(OUT_FRAME + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t         state_r, state_nxt;
  logic [LW-1:0]  in_idx_r, in_idx_nxt;
  logic [OW-1:0]  out_idx_r, out_idx_nxt;
  logic [LW-1:0]  left_r, left_nxt;
  logic [RW-1:0]  frac_r, frac_nxt;
  logic           last_in_r, last_in_nxt;

  logic           accept;
  logic           emit;
  logic           more;
  logic [RW:0]    frac_sum;
  logic           wrap;
  logic [RW-1:0]  frac_adv;
  logic [LW-1:0]  left_adv;
  logic [OW-1:0]  out_adv;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign cmd_frac = frac_r;

  assign frac_sum = {1'b0, frac_r} + (RW+1)'(STEP);
  assign wrap     = (frac_sum >= (RW+1)'(D));
  assign frac_adv = wrap ? RW'(frac_sum - (RW+1)'(D)) : frac_sum[RW-1:0];
  assign left_adv = left_r + LW'(wrap);
  assign out_adv  = out_idx_r + OW'(1);

  assign emit = (out_idx_r < OW'(OUT_FRAME)) && ((left_r < in_idx_r) || last_in_r);
  assign more = (out_adv < OW'(OUT_FRAME)) && ((left_adv < in_idx_r) || last_in_r);

  always_comb begin
    state_nxt   = state_r;
    in_idx_nxt  = in_idx_r;
    out_idx_nxt = out_idx_r;
    left_nxt    = left_r;
    frac_nxt    = frac_r;
    last_in_nxt = last_in_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (in_idx_r == '0) begin
            in_idx_nxt = LW'(1);
          end else begin
            last_in_nxt = (in_idx_r == LW'(IN_FRAME - 1));
            state_nxt   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!emit || dp_en) begin
          if (emit) begin
            cmd.issue       = 1'b1;
            cmd.a_cur       = !(left_r < in_idx_r);
            cmd.frame_end   = (out_idx_r == OW'(OUT_FRAME - 1));
            cmd.last_of_run = !more;
            out_idx_nxt     = out_adv;
            left_nxt        = left_adv;
            frac_nxt        = frac_adv;
          end
          if (!emit || !more) begin
            state_nxt = ST_IDLE;
            if (last_in_r) begin
              in_idx_nxt  = '0;
              out_idx_nxt = '0;
              left_nxt    = '0;
              frac_nxt    = '0;
            end else begin
              in_idx_nxt = in_idx_r + LW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      in_idx_r  <= '0;
      out_idx_r <= '0;
      left_r    <= '0;
      frac_r    <= '0;
      last_in_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_idx_r  <= in_idx_nxt;
      out_idx_r <= out_idx_nxt;
      left_r    <= left_nxt;
      frac_r    <= frac_nxt;
      last_in_r <= last_in_nxt;
    end
  end

endmodule

/* sv/lrs_dpath.sv */
`timescale 1ns / 1ps

module lrs_dpath #(
  parameter int OUT_FRAME = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [lrs_pkg::SMP_W-1:0]     in_sample,
  input  lrs_pkg::lrs_cmd_t                    cmd,
  input  logic [$clog2(OUT_FRAME)-1:0]         cmd_frac,
  output logic                                 dp_en,
  input  logic                                 cfg_wr_en,
  input  logic [lrs_pkg::VOL_W-1:0]            cfg_wr_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lrs_pkg::SMP_W-1:0]     out_sample,
  output logic                                 out_frame_end,
  output logic                                 out_last_of_run
);

  localparam int D = OUT_FRAME - 1;
  localparam int RW = $clog2(OUT_FRAME);
  localparam int NSW = 16 + RW;
  localparam int NW = 15 + RW;
  localparam int L1 = $clog2(D);
  localparam int S1 = NW + L1;
  localparam int M1W = NW + 2;
  localparam logic [63:0] M1_64 = ((64'd1 << S1) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [M1W-1:0] M1 = M1_64[M1W-1:0];
  localparam logic [RW-1:0] DV = RW'(D);

  logic [lrs_pkg::VOL_W-1:0] vol_r;
  logic signed [15:0]        prev_r, cur_r;

  logic [6:1]                v_r;
  logic [1:0]                fl1_r, fl2_r, fl3_r, fl4_r, fl5_r, fl6_r;
  logic                      neg3_r, neg4_r, neg5_r, neg6_r;

  logic signed [NSW-1:0]     pa1_r;
  logic signed [16:0]        d1_r;
  logic [RW-1:0]             frac1_r;
  logic signed [NSW-1:0]     n2_r;
  logic [NW-1:0]             mag3_r;
  logic [15:0]               q4_r;
  logic [lrs_pkg::P2_W-1:0]  p5_r;
  logic [15:0]               q6_r;

  logic                      out_valid_r;
  logic signed [15:0]        out_sample_r;
  logic                      out_frame_end_r;
  logic                      out_last_r;

  logic signed [15:0]        a_sel;
  logic signed [NSW:0]       pa_full;
  logic signed [RW+17:0]     prod_dr;
  logic signed [RW+17:0]     n_full;
  logic [NSW-1:0]            n_neg;
  logic [NW+M1W-1:0]         prod1;
  logic [22:0]               p5_full;
  logic [lrs_pkg::P2_W+lrs_pkg::M2_W-1:0] prod2;
  logic [15:0]               q6_neg;

  assign dp_en = !out_valid_r || !out_stall;

  assign a_sel   = cmd.a_cur ? cur_r : prev_r;
  assign pa_full = $signed(a_sel) * $signed({1'b0, DV});
  assign prod_dr = $signed(d1_r) * $signed({1'b0, frac1_r});
  assign n_full  = prod_dr + $signed({{2{pa1_r[NSW-1]}}, pa1_r});
  assign n_neg   = -n2_r;
  assign prod1   = mag3_r * M1;
  assign p5_full = q4_r * vol_r;
  assign prod2   = p5_r * lrs_pkg::M2;
  assign q6_neg  = -q6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r <= lrs_pkg::VOL_MAX;
    end else if (cfg_wr_en) begin
      vol_r <= (cfg_wr_data > lrs_pkg::VOL_MAX) ? lrs_pkg::VOL_MAX : cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_r <= cur_r;
      cur_r  <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (dp_en) begin
      v_r         <= {v_r[5:1], cmd.issue};
      out_valid_r <= v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_en) begin
      pa1_r   <= pa_full[NSW-1:0];
      d1_r    <= {cur_r[15], cur_r} - {a_sel[15], a_sel};
      frac1_r <= cmd_frac;
      fl1_r   <= {cmd.frame_end, cmd.last_of_run};

      n2_r    <= n_full[NSW-1:0];
      fl2_r   <= fl1_r;

      neg3_r  <= n2_r[NSW-1];
      mag3_r  <= n2_r[NSW-1] ? n_neg[NW-1:0] : n2_r[NW-1:0];
      fl3_r   <= fl2_r;

      q4_r    <= prod1[S1 +: 16];
      neg4_r  <= neg3_r;
      fl4_r   <= fl3_r;

      p5_r    <= p5_full[lrs_pkg::P2_W-1:0];
      neg5_r  <= neg4_r;
      fl5_r   <= fl4_r;

      q6_r    <= prod2[lrs_pkg::S2 +: 16];
      neg6_r  <= neg5_r;
      fl6_r   <= fl5_r;

      out_sample_r    <= neg6_r ? q6_neg : q6_r;
      out_frame_end_r <= fl6_r[1];
      out_last_r      <= fl6_r[0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_frame_end   = out_frame_end_r;
  assign out_last_of_run = out_last_r;

endmodule

/* sv/linear_resampler_371_to_1024.sv */
`timescale 1ns / 1ps

// Linear-interpolation resampler: frames of IN_FRAME mono samples become
// frames of OUT_FRAME samples, scaled by a volume in percent.
// Input channel: in_valid / in_stall / in_sample, one sample per word.
// Output channel: out_valid / out_stall with out_sample, out_frame_end (last
// word of an output frame) and out_last_of_run (last word released by one
// input sample). Config: cfg_wr_en / cfg_wr_data sets the volume, 0..100,
// larger values clamp to 100; write it only while the block is idle.
// Throughput: an input sample holds off the next one until the output sequencer
// has issued every output that it releases (at most 3 with the default sizes);
// the first sample of a frame releases none. The sequencer issues one output
// per cycle into the arithmetic pipeline while the output is not stalled.
// Pipeline: each output passes six multiply / reciprocal stages plus the
// output register.
// Reset: volume 100, frame position at the start of a frame, pipeline empty.
// A stall on the output freezes the pipeline and holds the sequencer on its
// next output; no data is lost.
module linear_resampler_371_to_1024 #(
  parameter int IN_FRAME = 371,
  parameter int OUT_FRAME = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lrs_pkg::SMP_W-1:0]  in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lrs_pkg::SMP_W-1:0]  out_sample,
  output logic                              out_frame_end,
  output logic                              out_last_of_run,
  input  logic                              cfg_wr_en,
  input  logic [lrs_pkg::VOL_W-1:0]         cfg_wr_data
);

  lrs_pkg::lrs_cmd_t               cmd;
  logic [$clog2(OUT_FRAME)-1:0]    cmd_frac;
  logic                            dp_en;

  lrs_ctrl #(
    .IN_FRAME  (IN_FRAME),
    .OUT_FRAME (OUT_FRAME)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_en    (dp_en),
    .cmd      (cmd),
    .cmd_frac (cmd_frac)
  );

  lrs_dpath #(
    .OUT_FRAME (OUT_FRAME)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample       (in_sample),
    .cmd             (cmd),
    .cmd_frac        (cmd_frac),
    .dp_en           (dp_en),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_frame_end   (out_frame_end),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTH
  a_no_issue_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !cmd.issue)
    else $error("output issued in the cycle a word is accepted");

  a_issue_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> dp_en)
    else $error("output issued while the pipeline is frozen");

  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_last_of_run)
    else $error("frame end word is not the last of its run");
`endif

endmodule

/* sim/resampled_word_checker.sv */
`timescale 1ns / 1ps

module resampled_word_checker #(
  parameter int IN_FRAME = 371,
  parameter int OUT_FRAME = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [lrs_pkg::SMP_W-1:0]  in_sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [lrs_pkg::SMP_W-1:0]  out_sample,
  input  logic                              out_frame_end,
  input  logic                              out_last_of_run,
  input  logic                              cfg_wr_en,
  input  logic [lrs_pkg::VOL_W-1:0]         cfg_wr_data,
  output int                                mismatch_count,
  output int                                words_pending
);

  localparam int SMP_W = lrs_pkg::SMP_W;
  localparam int VOL_W = lrs_pkg::VOL_W;
  localparam longint SPAN = OUT_FRAME - 1;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    frame_end;
    logic                    last_of_run;
  } out_word_t;

  out_word_t               expected_words[$];
  logic [VOL_W-1:0]        gain_pct;
  logic signed [SMP_W-1:0] held_sample;
  int                      next_in_pos;
  int                      next_out_pos;

  initial begin
    mismatch_count = 0;
    words_pending = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Queue every word that this input sample releases.
  task automatic interpolate_run(input logic signed [SMP_W-1:0] cur);
    out_word_t run_words[4];
    int        n;
    bit        last_in;
    longint    pos;
    longint    left;
    longint    frac;
    longint    a;
    longint    v;
    n = 0;
    last_in = (next_in_pos >= IN_FRAME - 1);
    if (next_in_pos != 0) begin
      while (next_out_pos < OUT_FRAME) begin
        pos = longint'(next_out_pos) * (IN_FRAME - 1);
        left = pos / SPAN;
        frac = pos % SPAN;
        if (left >= next_in_pos && !last_in) break;
        a = (left < next_in_pos) ? longint'(held_sample) : longint'(cur);
        v = (a * (SPAN - frac) + longint'(cur) * frac) / SPAN;
        v = (v * longint'(gain_pct)) / 100;
        run_words[n].sample = v[SMP_W-1:0];
        run_words[n].frame_end = (next_out_pos == OUT_FRAME - 1);
        run_words[n].last_of_run = 1'b0;
        n++;
        next_out_pos++;
      end
    end
    if (n > 0) run_words[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_words.push_back(run_words[i]);
    held_sample = cur;
    if (last_in) begin
      next_in_pos = 0;
      next_out_pos = 0;
    end else begin
      next_in_pos++;
    end
  endtask

  always @(posedge clk) begin : track
    out_word_t want;
    if (!rst_n) begin
      gain_pct = lrs_pkg::VOL_MAX;
      held_sample = '0;
      next_in_pos = 0;
      next_out_pos = 0;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) begin
        gain_pct = (cfg_wr_data > lrs_pkg::VOL_MAX) ? lrs_pkg::VOL_MAX : cfg_wr_data;
      end
      if (in_valid && !in_stall) interpolate_run(in_sample);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, sample", longint'(out_sample), 0);
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (out_sample !== want.sample)
            report_mismatch("out_sample", longint'(out_sample), longint'(want.sample));
          if (out_frame_end !== want.frame_end)
            report_mismatch("out_frame_end", longint'(out_frame_end), longint'(want.frame_end));
          if (out_last_of_run !== want.last_of_run)
            report_mismatch("out_last_of_run", longint'(out_last_of_run),
                            longint'(want.last_of_run));
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

/* sim/linear_resampler_371_to_1024_test.sv */
`timescale 1ns / 1ps

module linear_resampler_371_to_1024_test;

  localparam int SMP_W = lrs_pkg::SMP_W;
  localparam int VOL_W = lrs_pkg::VOL_W;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SEGMENTS = 6;
  localparam int EDGE_COUNT = 16;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_sample;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SMP_W-1:0] out_sample;
  logic                    out_frame_end;
  logic                    out_last_of_run;
  logic                    cfg_wr_en;
  logic [VOL_W-1:0]        cfg_wr_data;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int cycle_count = 0;
  int mismatch_count;
  int words_pending;

  logic signed [SMP_W-1:0] last_sent = '0;
  logic signed [SMP_W-1:0] edge_words[EDGE_COUNT] = '{
    16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
    16'sh0001, 16'sh5555, 16'shAAAA, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh8001, 16'sh7FFE
  };
  int segment_words[SEGMENTS] = '{30, 95, 85, 80, 80, 85};
  logic [VOL_W-1:0] segment_gain[SEGMENTS];

  linear_resampler_371_to_1024 u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_frame_end   (out_frame_end),
    .out_last_of_run (out_last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  resampled_word_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_frame_end   (out_frame_end),
    .out_last_of_run (out_last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .words_pending   (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [SMP_W-1:0] pick_sample(input logic signed [SMP_W-1:0] near);
    int sel;
    sel = $urandom_range(7);
    case (sel)
      0: pick_sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1, 2: pick_sample = near + SMP_W'($urandom_range(511)) - SMP_W'(256);
      default: pick_sample = SMP_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic signed [SMP_W-1:0] s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    last_sent = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the input until every word has come out, then let the pipeline settle.
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [VOL_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    segment_gain[0] = 7'd0;
    segment_gain[1] = 7'd101;
    segment_gain[2] = 7'd1;
    segment_gain[3] = VOL_W'($urandom_range(99, 2));
    segment_gain[4] = lrs_pkg::VOL_MAX;
    segment_gain[5] = VOL_W'($urandom_range(127));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_gain(7'd127);

    in_idle_pct = 19;
    out_idle_pct = 69;
    for (int i = 0; i < EDGE_COUNT; i++) send_word(edge_words[i]);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_words();
      write_gain(segment_gain[seg]);
      in_idle_pct = (seg < 2) ? 19 : (seg < 4) ? 69 : 0;
      out_idle_pct = (seg < 2) ? 69 : (seg < 4) ? 19 : 0;
      for (int i = 0; i < segment_words[seg]; i++) send_word(pick_sample(last_sent));
    end

    drain_words();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
